>>> rtl/core/priority_process_queue_unit_assert.svh
// assertion macros for the priority process queue checker
// each macro expands to one labeled concurrent assertion clocked on clk
`ifndef PRIORITY_PROCESS_QUEUE_UNIT_ASSERT_SVH
`define PRIORITY_PROCESS_QUEUE_UNIT_ASSERT_SVH

// checked only outside reset
`define PPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define PPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/ppq_pkg.sv
// shared types and codes for the priority process queue
// no dependencies
package ppq_pkg;

  localparam int OP_W  = 2;
  localparam int PID_W = 7;
  localparam int PRI_W = 4;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
  localparam logic [OP_W-1:0] OP_ENQUEUE  = 2'd1;
  localparam logic [OP_W-1:0] OP_EXECUTE  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [PID_W-1:0] process_id;
    logic [PRI_W-1:0] priority_req;
  } ppq_req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [PID_W-1:0] result_id;
    logic [PRI_W-1:0] result_priority;
  } ppq_rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } ppq_cmd_t;

endpackage

>>> rtl/core/ppq_ram.sv
// generic simple dual-port ram with registered read
// no dependencies
module ppq_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/ppq_ctrl.sv
// controller for the priority process queue: accept, execute, respond
// depends on ppq_pkg
module ppq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output ppq_pkg::ppq_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } ppq_state_t;

  ppq_state_t state;
  ppq_state_t state_next;

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.exec   = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.exec;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

>>> rtl/core/ppq_datapath.sv
// datapath: id counter, priority table ram, sorted shift-register ready queue
// depends on ppq_pkg and ppq_ram
module ppq_datapath #(
  parameter int MAX_PROCESSES = 64,
  parameter int QUEUE_DEPTH   = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  ppq_pkg::ppq_cmd_t cmd,
  input  ppq_pkg::ppq_req_t req,
  output ppq_pkg::ppq_rsp_t rsp
);

  localparam int IDX_W = $clog2(MAX_PROCESSES);
  localparam int ID_W  = $clog2(MAX_PROCESSES + 2);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = 8;

  ppq_pkg::ppq_req_t req_q;
  logic [ID_W-1:0]   next_id;
  logic [CNT_W-1:0]  count;

  logic [ppq_pkg::PID_W-1:0] q_id  [QUEUE_DEPTH];
  logic [ppq_pkg::PRI_W-1:0] q_pri [QUEUE_DEPTH];
  logic [ppq_pkg::PID_W-1:0] ins_id  [QUEUE_DEPTH];
  logic [ppq_pkg::PRI_W-1:0] ins_pri [QUEUE_DEPTH];
  logic [ppq_pkg::PID_W-1:0] pop_id  [QUEUE_DEPTH];
  logic [ppq_pkg::PRI_W-1:0] pop_pri [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]    ge;

  logic [ppq_pkg::PRI_W-1:0] tbl_pri;
  logic [ppq_pkg::PID_W-1:0] pid_m1;
  logic [ID_W-1:0]           next_id_m1;
  logic                      tbl_we;
  logic                      table_full;
  logic                      id_unknown;
  logic                      queue_full;
  logic                      queue_empty;
  logic                      do_ins;
  logic                      do_pop;

  assign pid_m1     = req.process_id - 7'd1;
  assign next_id_m1 = next_id - ID_W'(1);

  assign table_full  = (next_id > ID_W'(MAX_PROCESSES));
  assign id_unknown  = (req_q.process_id == '0)
                    || (CMP_W'(req_q.process_id) >= CMP_W'(next_id))
                    || (CMP_W'(req_q.process_id) > CMP_W'(MAX_PROCESSES));
  assign queue_full  = (count == CNT_W'(QUEUE_DEPTH));
  assign queue_empty = (count == '0);

  assign tbl_we = cmd.exec && (req_q.opcode == ppq_pkg::OP_REGISTER) && !table_full;
  assign do_ins = cmd.exec && (req_q.opcode == ppq_pkg::OP_ENQUEUE)
               && !id_unknown && !queue_full;
  assign do_pop = cmd.exec && (req_q.opcode == ppq_pkg::OP_EXECUTE) && !queue_empty;

  ppq_ram #(
    .WIDTH (ppq_pkg::PRI_W),
    .DEPTH (MAX_PROCESSES)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (next_id_m1[IDX_W-1:0]),
    .wdata (req_q.priority_req),
    .re    (cmd.load),
    .raddr (pid_m1[IDX_W-1:0]),
    .rdata (tbl_pri)
  );

  // queued entries at or above the new priority form a prefix; the new one goes after it
  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      ge[k] = (k < int'(count)) && (q_pri[k] >= tbl_pri);
    end
    ins_id[0]  = req_q.process_id;
    ins_pri[0] = tbl_pri;
    for (int k = 1; k < QUEUE_DEPTH; k++) begin
      ins_id[k]  = ge[k-1] ? req_q.process_id : q_id[k-1];
      ins_pri[k] = ge[k-1] ? tbl_pri : q_pri[k-1];
    end
    for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
      pop_id[k]  = q_id[k+1];
      pop_pri[k] = q_pri[k+1];
    end
    pop_id[QUEUE_DEPTH-1]  = q_id[QUEUE_DEPTH-1];
    pop_pri[QUEUE_DEPTH-1] = q_pri[QUEUE_DEPTH-1];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      if (do_ins && !ge[k]) begin
        q_id[k]  <= ins_id[k];
        q_pri[k] <= ins_pri[k];
      end else if (do_pop) begin
        q_id[k]  <= pop_id[k];
        q_pri[k] <= pop_pri[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_id <= ID_W'(1);
      count   <= '0;
    end else begin
      if (tbl_we) begin
        next_id <= next_id + ID_W'(1);
      end
      if (do_ins) begin
        count <= count + CNT_W'(1);
      end else if (do_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp.status          <= ppq_pkg::ST_OK;
      rsp.result_id       <= '0;
      rsp.result_priority <= '0;
      case (req_q.opcode)
        ppq_pkg::OP_REGISTER: begin
          if (table_full) begin
            rsp.status <= ppq_pkg::ST_FULL;
          end else begin
            rsp.result_id <= ppq_pkg::PID_W'(next_id);
          end
        end
        ppq_pkg::OP_ENQUEUE: begin
          if (id_unknown) begin
            rsp.status <= ppq_pkg::ST_NOT_FOUND;
          end else if (queue_full) begin
            rsp.status <= ppq_pkg::ST_FULL;
          end
        end
        ppq_pkg::OP_EXECUTE: begin
          if (queue_empty) begin
            rsp.status <= ppq_pkg::ST_EMPTY;
          end else begin
            rsp.result_id       <= q_id[0];
            rsp.result_priority <= q_pri[0];
          end
        end
        default: begin
          rsp.status <= ppq_pkg::ST_OK;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/priority_process_queue_unit.sv
// Priority process queue: registers processes with a priority, queues them by id
// and hands out the highest-priority one, ties first-in first-out. A request is
// taken when start is high and busy is low; its response appears on rsp with done
// high for exactly one cycle, registered at the end of the execute state that
// follows acceptance, and is taken at the following edge since there is no stall.
// A new request can be taken at that same edge, but none before the last is through;
// each passes the registered read of the priority table, then the execute state.
// Depends on ppq_pkg, ppq_ctrl, ppq_datapath.
module priority_process_queue_unit #(
  parameter int MAX_PROCESSES = 64,
  parameter int QUEUE_DEPTH   = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ppq_pkg::ppq_req_t req,
  output logic              done,
  output ppq_pkg::ppq_rsp_t rsp
);

  ppq_pkg::ppq_cmd_t cmd;

  ppq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  ppq_datapath #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

>>> rtl/core/ppq_checker.sv
// port-level checker for the priority process queue, bound to the top level
// depends on ppq_pkg and priority_process_queue_unit_assert.svh
`include "priority_process_queue_unit_assert.svh"

module ppq_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input ppq_pkg::ppq_rsp_t rsp
);

  `PPQ_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted request did not go busy")
  `PPQ_ASSERT(a_busy_done, busy |=> (done && !busy), "no response one cycle after busy")
  `PPQ_ASSERT(a_done_follows, done |-> $past(busy), "response without a request at work")
  `PPQ_ASSERT(a_err_zero, (done && rsp.status != ppq_pkg::ST_OK) |-> (rsp.result_id == '0 && rsp.result_priority == '0), "error response carries data")
  `PPQ_ASSERT_ALWAYS(a_reset_idle, rst |=> (!busy && !done), "not idle after reset")

endmodule

bind priority_process_queue_unit ppq_checker u_ppq_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

>>> tb/sv/priority_process_queue_unit_tb.sv
// testbench for priority_process_queue_unit: directed and random requests,
// every response checked against an in-bench scheduler model
// depends on ppq_pkg and the priority_process_queue_unit rtl
`timescale 1ns / 1ps

module priority_process_queue_unit_tb;

  localparam int MAX_PROCESSES = 64;
  localparam int QUEUE_DEPTH   = 16;
  localparam int RANDOM_ITEMS  = 950;
  localparam logic [ppq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  logic              clk   = 1'b0;
  logic              rst   = 1'b1;
  logic              start = 1'b0;
  ppq_pkg::ppq_req_t req   = '0;
  logic              busy;
  logic              done;
  ppq_pkg::ppq_rsp_t rsp;

  priority_process_queue_unit #(
    .MAX_PROCESSES(MAX_PROCESSES),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // scheduler model state
  int unsigned               next_pid = 1;
  logic [ppq_pkg::PRI_W-1:0] pid_priority [1:MAX_PROCESSES];
  logic [ppq_pkg::PID_W-1:0] ready_ids [$];
  logic [ppq_pkg::PRI_W-1:0] ready_pris [$];

  ppq_pkg::ppq_rsp_t pending_rsp [$];
  int                mismatch_count = 0;
  int                burst_left = 0;

  function automatic ppq_pkg::ppq_rsp_t predict_response(ppq_pkg::ppq_req_t item);
    ppq_pkg::ppq_rsp_t         r;
    int                        pos;
    logic [ppq_pkg::PRI_W-1:0] pri;
    r = '0;
    r.status = ppq_pkg::ST_OK;
    case (item.opcode)
      ppq_pkg::OP_REGISTER: begin
        if (next_pid > MAX_PROCESSES) begin
          r.status = ppq_pkg::ST_FULL;
        end else begin
          pid_priority[next_pid] = item.priority_req;
          r.result_id = next_pid[ppq_pkg::PID_W-1:0];
          next_pid++;
        end
      end
      ppq_pkg::OP_ENQUEUE: begin
        if (item.process_id == 0 || item.process_id >= next_pid) begin
          r.status = ppq_pkg::ST_NOT_FOUND;
        end else if (ready_ids.size() >= QUEUE_DEPTH) begin
          r.status = ppq_pkg::ST_FULL;
        end else begin
          pri = pid_priority[item.process_id];
          pos = 0;
          // behind every entry of equal or higher priority
          while (pos < ready_pris.size() && ready_pris[pos] >= pri) pos++;
          ready_ids.insert(pos, item.process_id);
          ready_pris.insert(pos, pri);
        end
      end
      ppq_pkg::OP_EXECUTE: begin
        if (ready_ids.size() == 0) begin
          r.status = ppq_pkg::ST_EMPTY;
        end else begin
          r.result_id = ready_ids.pop_front();
          r.result_priority = ready_pris.pop_front();
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic ppq_pkg::ppq_req_t make_req(logic [ppq_pkg::OP_W-1:0] op, int pid,
                                                 int pri);
    ppq_pkg::ppq_req_t item;
    item.opcode = op;
    item.process_id = pid[ppq_pkg::PID_W-1:0];
    item.priority_req = pri[ppq_pkg::PRI_W-1:0];
    return item;
  endfunction

  // called after a rising edge; returns after the accepting edge and any gap
  task automatic issue_request(ppq_pkg::ppq_req_t item);
    start <= 1'b1;
    req <= item;
    do @(posedge clk); while (busy);
    pending_rsp.push_back(predict_response(item));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  always @(posedge clk) begin : check_response
    ppq_pkg::ppq_rsp_t want;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $error("response with no request outstanding: status %0d id %0d priority %0d",
               rsp.status, rsp.result_id, rsp.result_priority);
        mismatch_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, rsp.status);
          mismatch_count++;
        end
        if (rsp.result_id !== want.result_id) begin
          $error("result_id expected %0d actual %0d", want.result_id, rsp.result_id);
          mismatch_count++;
        end
        if (rsp.result_priority !== want.result_priority) begin
          $error("result_priority expected %0d actual %0d",
                 want.result_priority, rsp.result_priority);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_idle_cases();
    issue_request(make_req(ppq_pkg::OP_EXECUTE, 0, 0));
    issue_request(make_req(OP_UNUSED, 127, 15));
    issue_request(make_req(ppq_pkg::OP_ENQUEUE, 0, 15));
    issue_request(make_req(ppq_pkg::OP_ENQUEUE, 1, 0));
    issue_request(make_req(ppq_pkg::OP_ENQUEUE, 127, 0));
  endtask

  // ties must leave in arrival order, repeated ids allowed
  task automatic test_priority_order();
    issue_request(make_req(ppq_pkg::OP_REGISTER, 127, 0));
    issue_request(make_req(ppq_pkg::OP_REGISTER, 0, 15));
    issue_request(make_req(ppq_pkg::OP_REGISTER, 85, 15));
    issue_request(make_req(ppq_pkg::OP_ENQUEUE, 1, 0));
    issue_request(make_req(ppq_pkg::OP_ENQUEUE, 2, 0));
    issue_request(make_req(ppq_pkg::OP_ENQUEUE, 3, 0));
    issue_request(make_req(ppq_pkg::OP_ENQUEUE, 2, 0));
    repeat (5) issue_request(make_req(ppq_pkg::OP_EXECUTE, 0, 0));
  endtask

  // unknown id is reported ahead of queue full
  task automatic test_queue_full();
    repeat (QUEUE_DEPTH) begin
      issue_request(make_req(ppq_pkg::OP_ENQUEUE, $urandom_range(1, 3), 0));
    end
    issue_request(make_req(ppq_pkg::OP_ENQUEUE, 3, 0));
    issue_request(make_req(ppq_pkg::OP_ENQUEUE, 99, 0));
  endtask

  task automatic test_random_mix();
    int enq_weight;
    int pick;
    int rand_op;
    enq_weight = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // every 50 items pick a filling, balanced or draining stretch at random
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: enq_weight = 25;
          1: enq_weight = 50;
          default: enq_weight = 75;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        rand_op = $urandom_range(0, 3);
        issue_request(make_req(rand_op[ppq_pkg::OP_W-1:0], $urandom_range(0, 127),
                               $urandom_range(0, 15)));
      end else if (pick < 18 || next_pid == 1) begin
        issue_request(make_req(ppq_pkg::OP_REGISTER, $urandom_range(0, 127),
                               $urandom_range(0, 15)));
      end else if ($urandom_range(0, 99) < enq_weight) begin
        issue_request(make_req(ppq_pkg::OP_ENQUEUE, $urandom_range(1, next_pid - 1),
                               $urandom_range(0, 15)));
      end else begin
        issue_request(make_req(ppq_pkg::OP_EXECUTE, $urandom_range(0, 127),
                               $urandom_range(0, 15)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_idle_cases();
    test_priority_order();
    test_queue_full();
    test_random_mix();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
